@@ design/dss_pkg.sv @@
// Package for the data set statistics engine.
// Holds word types, request codes, state and control types; no dependencies.
package dss_pkg;

    localparam int SB    = 16;   // sample width
    localparam int POS_W = 11;   // width of count and position fields

    localparam logic [1:0] REQ_APPEND        = 2'd0;
    localparam logic [1:0] REQ_APPEND_REPORT = 2'd1;
    localparam logic [1:0] REQ_REPORT        = 2'd2;
    localparam logic [1:0] REQ_CLEAR         = 2'd3;

    typedef struct packed {
        logic [1:0]    req_type;
        logic [SB-1:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [SB-1:0]    mean_value;
        logic [SB-1:0]    max_value;
        logic [POS_W-1:0] max_position;
        logic [SB-1:0]    min_value;
        logic [POS_W-1:0] min_position;
        logic [POS_W-1:0] above_mean_count;
        logic [SB-1:0]    median_value;
        logic [SB-1:0]    mode_value;
        logic             mode_unique;
        logic [POS_W-1:0] set_size;
        logic             set_empty;
        logic             samples_dropped;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN,
        ST_DIVW,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic insert;
        logic rotate;
    } t_cell_ctl;

    typedef struct packed {
        logic start;
        logic take;
        logic close;
    } t_walk_ctl;

endpackage

@@ design/dss_cell.sv @@
// One cell of the sorted sample chain: holds one sample and its valid bit.
// Depends on dss_pkg. Inserts in sorted order or rotates towards cell 0.
module dss_cell
    import dss_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [SB-1:0] i_sample,
    input  logic [SB-1:0] i_lft_val,
    input  logic          i_lft_vld,
    input  logic          i_lft_gt,
    input  logic [SB-1:0] i_rgt_val,
    input  logic          i_rgt_vld,
    output logic [SB-1:0] o_val,
    output logic          o_vld,
    output logic          o_gt
);

    logic [SB-1:0] r_val;
    logic          r_vld;

    // an empty cell counts as greater than any sample
    assign o_gt  = !r_vld || (r_val > i_sample);
    assign o_val = r_val;
    assign o_vld = r_vld;

    // hold the valid bit; clear drops the whole set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.insert && o_gt) begin
            r_vld <= i_lft_gt ? i_lft_vld : 1'b1;
        end else if (i_ctl.rotate) begin
            r_vld <= i_rgt_vld;
        end
    end

    // take the new sample at the boundary, shift larger ones up
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && o_gt) begin
            r_val <= i_lft_gt ? i_lft_val : i_sample;
        end else if (i_ctl.rotate) begin
            r_val <= i_rgt_val;
        end
    end

endmodule

@@ design/dss_walk.sv @@
// Report evaluator: reads the sorted set one sample a cycle from the chain head.
// Depends on dss_pkg. Counts samples above mean, finds median and mode, divides sum.
module dss_walk
    import dss_pkg::*;
#(
    parameter int CW = 11,
    parameter int SW = 27
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_walk_ctl     i_ctl,
    input  logic [SB-1:0] i_val,
    input  logic [CW-1:0] i_idx,
    input  logic [CW-1:0] i_n,
    input  logic [SW-1:0] i_sum,
    output logic [CW-1:0] o_above,
    output logic [SB-1:0] o_median,
    output logic [SB-1:0] o_mode,
    output logic          o_mode_unique,
    output logic [SB-1:0] o_mean,
    output logic          o_div_done
);

    localparam int DCW = $clog2(SW + 1);

    logic [CW-1:0]    r_above;
    logic [SB-1:0]    r_lo;
    logic [SB-1:0]    r_hi;
    logic [SB-1:0]    r_prev;
    logic [CW-1:0]    r_run;
    logic [CW-1:0]    r_best;
    logic             r_multi;
    logic [SB-1:0]    r_modev;
    logic [CW:0]      r_rem;
    logic [SW-1:0]    r_quo;
    logic [DCW-1:0]   r_dcnt;

    logic [SB+CW-1:0] prod;
    logic [CW-1:0]    mid;
    logic             do_close;
    logic [CW:0]      trial;
    logic [SB:0]      med_sum;
    logic             above_hit;

    assign prod      = (SB+CW)'(i_val) * (SB+CW)'(i_n);
    assign mid       = i_n >> 1;
    assign do_close  = i_ctl.close || (i_ctl.take && (i_idx != '0) && (i_val != r_prev));
    assign trial     = {r_rem[CW-1:0], r_quo[SW-1]};
    assign med_sum   = (SB+1)'(r_lo) + (SB+1)'(r_hi);
    assign above_hit = i_ctl.take && ((SB+CW+1)'(prod) > (SB+CW+1)'(i_sum));

    // count samples whose scaled value exceeds the sum; the first sample
    // arrives together with start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= '0;
        end else if (i_ctl.start) begin
            r_above <= above_hit ? CW'(1) : CW'(0);
        end else if (above_hit) begin
            r_above <= r_above + 1'b1;
        end
    end

    // capture the middle samples
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            if (i_n[0]) begin
                if (i_idx == mid) begin
                    r_lo <= i_val;
                    r_hi <= i_val;
                end
            end else begin
                if (i_idx == mid - 1'b1) r_lo <= i_val;
                if (i_idx == mid)        r_hi <= i_val;
            end
        end
    end

    // track runs of equal samples
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_prev <= i_val;
            r_run  <= do_close || (i_idx == '0) ? CW'(1) : r_run + 1'b1;
        end
    end

    // close a run against the best frequency so far
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.start) begin
            r_best  <= '0;
            r_multi <= 1'b0;
        end else if (do_close) begin
            if (r_run > r_best) begin
                r_best  <= r_run;
                r_multi <= 1'b0;
                r_modev <= r_prev;
            end else if (r_run == r_best) begin
                r_multi <= 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_ctl.start) begin
            r_dcnt <= DCW'(SW);
            r_rem  <= '0;
            r_quo  <= i_sum;
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
            if (trial >= (CW+1)'(i_n)) begin
                r_rem <= trial - (CW+1)'(i_n);
                r_quo <= {r_quo[SW-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[SW-2:0], 1'b0};
            end
        end
    end

    assign o_above       = r_above;
    assign o_median      = med_sum[SB:1];
    assign o_mode        = r_multi ? '0 : r_modev;
    assign o_mode_unique = !r_multi;
    assign o_mean        = r_quo[SB-1:0];
    assign o_div_done    = (r_dcnt == '0) && !i_ctl.start;

endmodule

@@ design/data_set_statistics_engine.sv @@
// Top level of the data set statistics engine.
// Depends on dss_pkg, dss_cell and dss_walk.
//
// Input channel i_valid/o_ready carries a word of request type and sample.
// Output channel o_valid/i_ready carries one statistics word per report.
// A stream of appends and clears runs at one word a cycle while no report
// is at work: each append inserts the sample into a sorted chain of
// MAX_SAMPLES cells in the cycle that it is accepted.
// A report (request 1 or 2) rotates the whole chain once past the evaluator,
// one cell a cycle, then closes the last run and waits for the divider; the
// registered result is then shown. A report on an empty set skips the walk.
// The chain length, not the set size, sets the report time.
// The input is not ready while a report is at work or its result waits; a
// stalled receiver holds the result word stable until it is taken.
// Reset empties the set and clears the count, sum and drop flag; the sample
// values themselves need no clearing, as only valid cells are ever read.
module data_set_statistics_engine
    import dss_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_in_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_out_word
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int KW = $clog2(MAX_SAMPLES);
    localparam int SW = SB + CW;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_sum;
    logic          r_drop;
    logic [SB-1:0] r_max;
    logic [CW-1:0] r_maxpos;
    logic [SB-1:0] r_min;
    logic [CW-1:0] r_minpos;
    logic [KW-1:0] r_k;
    t_out_word     r_res;
    t_out_word     n_res;

    logic          in_acc;
    logic          out_acc;
    logic          is_append;
    logic          is_report;
    logic          room;
    logic          insert;
    logic          next_empty;
    t_cell_ctl     cell_ctl;
    t_walk_ctl     walk_ctl;

    logic [SB-1:0] c_val [MAX_SAMPLES];
    logic          c_vld [MAX_SAMPLES];
    logic          c_gt  [MAX_SAMPLES];

    logic [CW-1:0] w_above;
    logic [SB-1:0] w_median;
    logic [SB-1:0] w_mode;
    logic          w_mode_unique;
    logic [SB-1:0] w_mean;
    logic          w_div_done;

    assign o_ready    = (r_state == ST_IDLE);
    assign o_valid    = (r_state == ST_OUT);
    assign o_out_word = r_res;
    assign in_acc     = i_valid && o_ready;
    assign out_acc    = o_valid && i_ready;
    assign is_append  = (i_in_word.req_type == REQ_APPEND)
                     || (i_in_word.req_type == REQ_APPEND_REPORT);
    assign is_report  = (i_in_word.req_type == REQ_APPEND_REPORT)
                     || (i_in_word.req_type == REQ_REPORT);
    assign room       = (r_count < CW'(MAX_SAMPLES));
    assign insert     = in_acc && is_append && room;
    assign next_empty = (r_count == '0) && !insert;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && is_report) n_state = next_empty ? ST_OUT : ST_WALK;
            end
            ST_WALK: begin
                if (r_k == KW'(MAX_SAMPLES - 1)) n_state = ST_FIN;
            end
            ST_FIN:  n_state = ST_DIVW;
            ST_DIVW: begin
                if (w_div_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_acc) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs to the chain and the evaluator
    always_comb begin
        cell_ctl.clear  = in_acc && (i_in_word.req_type == REQ_CLEAR);
        cell_ctl.insert = insert;
        cell_ctl.rotate = (r_state == ST_WALK);
        walk_ctl.start  = (r_state == ST_WALK) && (r_k == '0);
        walk_ctl.take   = (r_state == ST_WALK) && (CW'(r_k) < r_count);
        walk_ctl.close  = (r_state == ST_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // walk counter
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WALK) begin
            r_k <= r_k + 1'b1;
        end else begin
            r_k <= '0;
        end
    end

    // set bookkeeping: count, sum, drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cell_ctl.clear) begin
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else if (in_acc && is_append) begin
            if (room) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SW'(i_in_word.sample);
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    // running extremes with first positions
    always_ff @(posedge i_clk) begin
        if (insert) begin
            if ((r_count == '0) || (i_in_word.sample > r_max)) begin
                r_max    <= i_in_word.sample;
                r_maxpos <= r_count + 1'b1;
            end
            if ((r_count == '0) || (i_in_word.sample < r_min)) begin
                r_min    <= i_in_word.sample;
                r_minpos <= r_count + 1'b1;
            end
        end
    end

    // assemble the result word
    always_comb begin
        n_res = r_res;
        if (r_state == ST_IDLE) begin
            n_res = '0;
            n_res.set_empty       = 1'b1;
            n_res.samples_dropped = r_drop || (in_acc && is_append && !room);
        end else if ((r_state == ST_DIVW) && w_div_done) begin
            n_res.mean_value       = w_mean;
            n_res.max_value        = r_max;
            n_res.max_position     = POS_W'(r_maxpos);
            n_res.min_value        = r_min;
            n_res.min_position     = POS_W'(r_minpos);
            n_res.above_mean_count = POS_W'(w_above);
            n_res.median_value     = w_median;
            n_res.mode_value       = w_mode;
            n_res.mode_unique      = w_mode_unique;
            n_res.set_size         = POS_W'(r_count);
            n_res.set_empty        = 1'b0;
            n_res.samples_dropped  = r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // sorted chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_SAMPLES; gi++) begin : g_cell
            localparam int LI = (gi == 0) ? 0 : gi - 1;
            localparam int RI = (gi == MAX_SAMPLES - 1) ? 0 : gi + 1;
            dss_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (cell_ctl),
                .i_sample  (i_in_word.sample),
                .i_lft_val (c_val[LI]),
                .i_lft_vld (c_vld[LI]),
                .i_lft_gt  ((gi == 0) ? 1'b0 : c_gt[LI]),
                .i_rgt_val (c_val[RI]),
                .i_rgt_vld (c_vld[RI]),
                .o_val     (c_val[gi]),
                .o_vld     (c_vld[gi]),
                .o_gt      (c_gt[gi])
            );
        end
    endgenerate

    dss_walk #(
        .CW (CW),
        .SW (SW)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (walk_ctl),
        .i_val         (c_val[0]),
        .i_idx         (CW'(r_k)),
        .i_n           (r_count),
        .i_sum         (r_sum),
        .o_above       (w_above),
        .o_median      (w_median),
        .o_mode        (w_mode),
        .o_mode_unique (w_mode_unique),
        .o_mean        (w_mean),
        .o_div_done    (w_div_done)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for data_set_statistics_engine: directed table, a fill past capacity, then random requests.
// Depends on dss_pkg; predicts each report word (or takes it from the directed table) and checks it field by field.
module tb_top;
    import dss_pkg::*;

    localparam int CAPACITY = 1024;
    localparam int N_RANDOM = 700;
    localparam longint CYCLE_LIMIT = 3000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_in_word = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_out_word;

    data_set_statistics_engine #(.MAX_SAMPLES(CAPACITY)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_in_word(i_in_word), .o_valid(o_valid), .i_ready(i_ready),
        .o_out_word(o_out_word)
    );

    // Predictor state
    logic [SB-1:0] set_store [CAPACITY];
    int unsigned   set_count;
    longint unsigned set_sum;
    bit            set_dropped;

    t_out_word report_queue [$];
    int        errors = 0;
    bit        hold_off_req = 1'b0;
    bit        quiet_phase = 1'b0;
    longint    cycle_count = 0;

    // Directed table
    typedef struct {
        logic [1:0]    req;
        logic [SB-1:0] smp;
        bit            typed;
        t_out_word     exp;
    } t_row;
    t_row dir_rows [$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Work out the report word for the current set
    function automatic t_out_word stats_report();
        t_out_word r;
        logic [SB-1:0] srt [$];
        int unsigned run, best, nbest;
        logic [SB-1:0] modev;
        r = '0;
        r.samples_dropped = set_dropped;
        if (set_count == 0) begin
            r.set_empty = 1'b1;
            return r;
        end
        r.max_value = set_store[0]; r.max_position = 1;
        r.min_value = set_store[0]; r.min_position = 1;
        for (int i = 0; i < set_count; i++) begin
            if (set_store[i] > r.max_value) begin
                r.max_value = set_store[i]; r.max_position = i + 1;
            end
            if (set_store[i] < r.min_value) begin
                r.min_value = set_store[i]; r.min_position = i + 1;
            end
            if (longint'(set_store[i]) * set_count > set_sum)
                r.above_mean_count++;
            srt.push_back(set_store[i]);
        end
        srt.sort();
        if (set_count % 2)
            r.median_value = srt[set_count / 2];
        else
            r.median_value = (17'(srt[set_count/2 - 1]) + 17'(srt[set_count/2])) >> 1;
        run = 0; best = 0; nbest = 0; modev = '0;
        for (int i = 0; i < set_count; i++) begin
            run++;
            if (i + 1 == set_count || srt[i+1] != srt[i]) begin
                if (run > best) begin
                    best = run; nbest = 1; modev = srt[i];
                end else if (run == best) begin
                    nbest++;
                end
                run = 0;
            end
        end
        r.mode_unique = (nbest == 1);
        r.mode_value = (nbest == 1) ? modev : '0;
        r.mean_value = SB'(set_sum / set_count);
        r.set_size = POS_W'(set_count);
        return r;
    endfunction

    // Advance the predictor by one accepted word; returns 1 if a report is due
    function automatic bit stats_apply(t_in_word w, output t_out_word r);
        r = '0;
        if (w.req_type == REQ_CLEAR) begin
            set_count = 0; set_sum = 0; set_dropped = 1'b0;
            return 1'b0;
        end
        if (w.req_type == REQ_APPEND || w.req_type == REQ_APPEND_REPORT) begin
            if (set_count < CAPACITY) begin
                set_store[set_count] = w.sample;
                set_count++;
                set_sum += w.sample;
            end else begin
                set_dropped = 1'b1;
            end
        end
        if (w.req_type == REQ_APPEND) return 1'b0;
        r = stats_report();
        return 1'b1;
    endfunction

    // Send one word, hold it until accepted, and queue the expected report word if it asks for one
    task automatic send_word(logic [1:0] req, logic [SB-1:0] smp, bit typed, t_out_word exp);
        t_out_word r;
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_word <= '{req_type: req, sample: smp};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (stats_apply('{req_type: req, sample: smp}, r))
            report_queue.push_back(typed ? exp : r);
        @(negedge i_clk);
    endtask

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 18);
                i_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Check each accepted report word
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && i_ready) begin
            if (report_queue.size() == 0) begin
                $display("%0t: unexpected report word %h", $time, o_out_word);
                errors++;
            end else begin
                e = report_queue.pop_front();
                if (e.mean_value !== o_out_word.mean_value) begin
                    $display("%0t: mean exp %h got %h", $time, e.mean_value,
                             o_out_word.mean_value); errors++; end
                if (e.max_value !== o_out_word.max_value) begin
                    $display("%0t: max exp %h got %h", $time, e.max_value,
                             o_out_word.max_value); errors++; end
                if (e.max_position !== o_out_word.max_position) begin
                    $display("%0t: max pos exp %0d got %0d", $time, e.max_position,
                             o_out_word.max_position); errors++; end
                if (e.min_value !== o_out_word.min_value) begin
                    $display("%0t: min exp %h got %h", $time, e.min_value,
                             o_out_word.min_value); errors++; end
                if (e.min_position !== o_out_word.min_position) begin
                    $display("%0t: min pos exp %0d got %0d", $time, e.min_position,
                             o_out_word.min_position); errors++; end
                if (e.above_mean_count !== o_out_word.above_mean_count) begin
                    $display("%0t: above exp %0d got %0d", $time, e.above_mean_count,
                             o_out_word.above_mean_count); errors++; end
                if (e.median_value !== o_out_word.median_value) begin
                    $display("%0t: median exp %h got %h", $time, e.median_value,
                             o_out_word.median_value); errors++; end
                if (e.mode_value !== o_out_word.mode_value) begin
                    $display("%0t: mode exp %h got %h", $time, e.mode_value,
                             o_out_word.mode_value); errors++; end
                if (e.mode_unique !== o_out_word.mode_unique) begin
                    $display("%0t: mode unique exp %b got %b", $time, e.mode_unique,
                             o_out_word.mode_unique); errors++; end
                if (e.set_size !== o_out_word.set_size) begin
                    $display("%0t: size exp %0d got %0d", $time, e.set_size,
                             o_out_word.set_size); errors++; end
                if (e.set_empty !== o_out_word.set_empty) begin
                    $display("%0t: empty exp %b got %b", $time, e.set_empty,
                             o_out_word.set_empty); errors++; end
                if (e.samples_dropped !== o_out_word.samples_dropped) begin
                    $display("%0t: dropped exp %b got %b", $time, e.samples_dropped,
                             o_out_word.samples_dropped); errors++; end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_row row(logic [1:0] req, logic [SB-1:0] smp);
        t_row t;
        t.req = req; t.smp = smp; t.typed = 1'b0; t.exp = '0;
        return t;
    endfunction

    // Main stimulus
    initial begin
        t_row t;
        t_out_word none;
        int len, k;
        logic [1:0] rq;
        logic [SB-1:0] s;
        none = '0;
        set_count = 0; set_sum = 0; set_dropped = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty report, extremes, ties, single element
        t = row(REQ_REPORT, 16'h0); t.typed = 1; t.exp.set_empty = 1; dir_rows.push_back(t);
        t = row(REQ_APPEND_REPORT, 16'hFFFF); t.typed = 1;
        t.exp = '{16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 1, 0, 16'hFFFF, 16'hFFFF, 1, 1, 0, 0};
        dir_rows.push_back(t);
        dir_rows.push_back(row(REQ_APPEND, 16'h0000));
        dir_rows.push_back(row(REQ_REPORT, 16'h1234));
        dir_rows.push_back(row(REQ_APPEND, 16'h0000));
        dir_rows.push_back(row(REQ_APPEND, 16'hFFFF));
        dir_rows.push_back(row(REQ_APPEND_REPORT, 16'h5555));
        dir_rows.push_back(row(REQ_APPEND, 16'hAAAA));
        dir_rows.push_back(row(REQ_REPORT, 16'h0));
        t = row(REQ_CLEAR, 16'hFFFF); dir_rows.push_back(t);
        t = row(REQ_REPORT, 16'h0); t.typed = 1; t.exp.set_empty = 1; dir_rows.push_back(t);
        dir_rows.push_back(row(REQ_APPEND, 16'h0100));
        dir_rows.push_back(row(REQ_APPEND, 16'h0100));
        dir_rows.push_back(row(REQ_APPEND, 16'h0001));
        dir_rows.push_back(row(REQ_APPEND_REPORT, 16'h0001));
        dir_rows.push_back(row(REQ_CLEAR, 16'h0));
        foreach (dir_rows[i]) send_word(dir_rows[i].req, dir_rows[i].smp,
                                        dir_rows[i].typed, dir_rows[i].exp);

        // Fill past capacity, with a long receiver hold-off over the reports
        for (int i = 0; i < CAPACITY + 3; i++)
            send_word(REQ_APPEND, 16'($urandom_range(0, 7)), 0, none);
        hold_off_req = 1'b1;
        send_word(REQ_APPEND_REPORT, 16'h8000, 0, none);
        send_word(REQ_REPORT, 16'h0, 0, none);
        send_word(REQ_REPORT, 16'h0, 0, none);
        send_word(REQ_CLEAR, 16'h0, 0, none);

        // Random: short sets of appends closed by reports, with some noise
        k = 0;
        while (k < N_RANDOM) begin
            if (k > N_RANDOM * 4 / 5) quiet_phase = 1'b1;
            len = $urandom_range(0, 12);
            for (int j = 0; j < len; j++) begin
                case ($urandom_range(0, 3))
                    0: s = 16'($urandom);
                    1: s = 16'($urandom_range(0, 3));
                    2: s = 16'hFFFF - 16'($urandom_range(0, 2));
                    default: s = 16'($urandom_range(250, 260));
                endcase
                send_word(REQ_APPEND, s, 0, none); k++;
            end
            rq = ($urandom_range(0, 1)) ? REQ_REPORT : REQ_APPEND_REPORT;
            send_word(rq, 16'($urandom), 0, none); k++;
            if ($urandom_range(0, 3) == 0) begin
                send_word(REQ_CLEAR, 16'($urandom), 0, none); k++;
            end
        end
        i_valid <= 1'b0;

        while (report_queue.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 20) @(posedge i_clk);
        if (errors == 0 && report_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ files.f @@
design/dss_pkg.sv
design/dss_cell.sv
design/dss_walk.sv
design/data_set_statistics_engine.sv
tb/tb_top.sv
